// File: rtl/ksd_pkg.sv
// ----------------------------------------------------------------------------
// ksd_pkg: shared types and constants for the keypad scan / debounce core
// Field widths, register reset value and the poll record passed from the
// encoder to the debounce machine.
// ----------------------------------------------------------------------------
`default_nettype none

package ksd_pkg;

  // Field widths
  localparam int MATRIX_W = 16;
  localparam int TIME_W   = 32;
  localparam int KEY_W    = 5;
  localparam int DEB_W    = 16;

  // Default matrix geometry
  localparam int ROWS_DEF = 4;
  localparam int COLS_DEF = 4;

  // Debounce threshold after reset, in ms
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(10);

  // Stream bus widths (fields packed from bit 0, padded to bytes)
  localparam int IN_TDATA_W  = ((MATRIX_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((KEY_W + 7) / 8) * 8;

  // One encoded poll
  typedef struct packed {
    logic [KEY_W-1:0]  code;
    logic [TIME_W-1:0] now_ms;
  } poll_t;

endpackage

`default_nettype wire

// File: rtl/ksd_encoder.sv
// ----------------------------------------------------------------------------
// ksd_encoder: key matrix priority encoder
// The first set cell in row-major order gives code row*COLS+col+1; no set
// cell gives 0. Cells past the input width never read as pressed.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_encoder
  import ksd_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic [MATRIX_W-1:0] key_matrix,
  input  wire logic [TIME_W-1:0]   now_ms,
  output      poll_t               poll
);

  localparam int CELLS = ROWS * COLS;
  localparam int EXT_W = (CELLS > MATRIX_W) ? CELLS : MATRIX_W;

  logic [EXT_W-1:0] ext;
  logic [CELLS-1:0] cells;
  logic [KEY_W-1:0] code;

  // Zero-extend so cells beyond the input width read as released
  assign ext   = EXT_W'(key_matrix);
  assign cells = ext[CELLS-1:0];

  // Lowest set cell wins: scan from the top down, last hit sticks
  always_comb begin
    code = '0;
    for (int i = CELLS - 1; i >= 0; i--) begin
      if (cells[i]) begin
        code = KEY_W'(i + 1);
      end
    end
  end

  assign poll.code   = code;
  assign poll.now_ms = now_ms;

endmodule

`default_nettype wire

// File: rtl/ksd_debounce.sv
// ----------------------------------------------------------------------------
// ksd_debounce: three-phase debounce machine
// Tracks the previous code, the press timestamp and the latched key; the
// latched key is reported on the poll where it is released or changes.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_debounce
  import ksd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire poll_t            poll,
  input  wire logic [DEB_W-1:0] debounce_ms,
  output      logic [KEY_W-1:0] result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_HELD
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [KEY_W-1:0]   last_key_r;
  logic [TIME_W-1:0]  press_time_r, press_time_nxt;
  logic [KEY_W-1:0]   held_key_r, held_key_nxt;
  logic               same;
  logic               stable_press;
  logic [TIME_W-1:0]  elapsed;

  assign same         = (last_key_r == poll.code);
  assign stable_press = same && (last_key_r != '0);
  assign elapsed      = poll.now_ms - press_time_r;

  // Next phase and report for the current poll
  always_comb begin
    phase_nxt      = phase_r;
    press_time_nxt = press_time_r;
    held_key_nxt   = held_key_r;
    result         = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (stable_press) begin
          phase_nxt      = PH_DEBOUNCE;
          press_time_nxt = poll.now_ms;
        end
      end
      PH_DEBOUNCE: begin
        if (!same) begin
          phase_nxt = PH_IDLE;
        end else if (elapsed > TIME_W'(debounce_ms)) begin
          held_key_nxt = poll.code;
          phase_nxt    = PH_HELD;
        end
      end
      PH_HELD: begin
        if (!stable_press) begin
          phase_nxt = PH_IDLE;
          result    = held_key_r;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // State update, one poll per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      last_key_r   <= '0;
      press_time_r <= '0;
      held_key_r   <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      last_key_r   <= poll.code;
      press_time_r <= press_time_nxt;
      held_key_r   <= held_key_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/keypad_scan_debounce_core.sv
// Path: input register, then encoder and debounce machine, then output register.
// Throughput: 1 item per cycle while the result side is not stalled; the
//   debounce machine updates once per item, input register to output register.
// Reset: synchronous, active low; clears the valid flags of both pipeline
//   registers, clears the debounce machine, and sets debounce_ms to 10.
// ----------------------------------------------------------------------------
// keypad_scan_debounce_core: keypad scanner with debounce, stream top level
// Input register, encoder and debounce machine, output register. One
// result item per input item.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_debounce_core
  import ksd_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [DEB_W-1:0]       cfg_wr_data,
  // Input stream
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] key_matrix, [47:16] now_ms
  // Result stream
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata   // [4:0] key_code, rest zero
);

  logic                   s1_valid_r;
  logic [MATRIX_W-1:0]    matrix_r;
  logic [TIME_W-1:0]      now_r;
  logic                   out_valid_r;
  logic [KEY_W-1:0]       out_code_r;
  logic [DEB_W-1:0]       debounce_ms_r;
  logic                   advance;
  logic                   in_fire;
  poll_t                  poll;
  logic [KEY_W-1:0]       result;

  // Pipeline control
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // Debounce threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_ms_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      matrix_r <= in_tdata[MATRIX_W-1:0];
      now_r    <= in_tdata[MATRIX_W+TIME_W-1:MATRIX_W];
    end
  end

  ksd_encoder #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_encoder (
    .key_matrix (matrix_r),
    .now_ms     (now_r),
    .poll       (poll)
  );

  ksd_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .poll        (poll),
    .debounce_ms (debounce_ms_r),
    .result      (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_code_r);

endmodule

`default_nettype wire

// File: rtl/ksd_checker.sv
// ----------------------------------------------------------------------------
// ksd_checker: port-level checks for the keypad scan / debounce core
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_checker
  import ksd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic out_fire;
  logic out_key;

  assign out_fire = out_tvalid && out_tready;
  assign out_key  = out_tdata[KEY_W-1:0] != '0;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A ready sink always lets a new item in
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while result side is ready");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A release report sends the machine to idle, so the next result is 0
  a_no_double_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_key |=> !(out_fire && out_key))
    else $error("two key reports on consecutive results");

endmodule

bind keypad_scan_debounce_core ksd_checker u_ksd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: tb/keypad_scan_debounce_core_tb.sv
// ----------------------------------------------------------------------------
// keypad_scan_debounce_core_tb: self-checking bench for the keypad scanner
// Polls go in on the input stream and the bench computes, per accepted poll,
// the key code the debounce machine must report. Each result item is popped
// against that queue. A directed key sequence comes first. Random keystrokes,
// bounces, noise and time jumps follow under four debounce settings, with
// random gaps on both sides and one long result stall.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_debounce_core_tb;
  import ksd_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int ITEMS_PER_SETTING = 250;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2
  } deb_phase_t;

  // Predicted key codes, one per accepted poll, plus the mismatch count
  class key_scoreboard;
    logic [DEB_W-1:0]  debounce_ms;
    deb_phase_t        phase;
    logic [KEY_W-1:0]  last_key;
    logic [KEY_W-1:0]  held_key;
    logic [TIME_W-1:0] press_time;
    logic [KEY_W-1:0]  expected_keys[$];
    int                mismatches;

    function new();
      debounce_ms = DEBOUNCE_RESET;
      phase       = PH_IDLE;
      last_key    = '0;
      held_key    = '0;
      press_time  = '0;
      mismatches  = 0;
    endfunction

    // Encode the poll, step the debounce machine, queue the reported key
    function void note_poll(logic [MATRIX_W-1:0] keys, logic [TIME_W-1:0] now);
      logic [KEY_W-1:0]  prev;
      logic [KEY_W-1:0]  cur;
      logic [KEY_W-1:0]  key_out;
      logic [TIME_W-1:0] elapsed;
      logic              same;
      int                idx;
      // first set cell in row-major order wins: scan backwards, keep last hit
      cur = '0;
      for (int r = ROWS_DEF - 1; r >= 0; r--) begin
        for (int c = COLS_DEF - 1; c >= 0; c--) begin
          idx = r * COLS_DEF + c;
          if (idx < MATRIX_W && keys[idx]) begin
            cur = KEY_W'(idx + 1);
          end
        end
      end
      prev     = last_key;
      same     = (prev == cur);
      last_key = cur;
      key_out  = '0;
      elapsed  = now - press_time;
      case (phase)
        PH_IDLE: begin
          if (same && prev != '0) begin
            phase      = PH_DEBOUNCE;
            press_time = now;
          end
        end
        PH_DEBOUNCE: begin
          if (!same) begin
            phase = PH_IDLE;
          end else if (elapsed > TIME_W'(debounce_ms)) begin
            held_key = cur;
            phase    = PH_HELD;
          end
        end
        PH_HELD: begin
          if (!(same && prev != '0)) begin
            phase   = PH_IDLE;
            key_out = held_key;
          end
        end
        default: begin
          phase = PH_IDLE;
        end
      endcase
      expected_keys.push_back(key_out);
    endfunction

    // Compare one result item against the oldest prediction
    function void check_key(logic [OUT_TDATA_W-1:0] got);
      logic [OUT_TDATA_W-1:0] want;
      if (expected_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result item 0x%0h arrived with no poll pending", got);
        end
        return;
      end
      want = OUT_TDATA_W'(expected_keys.pop_front());
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: key_code expected %0d got %0d (tdata 0x%0h)",
                   want[KEY_W-1:0], got[KEY_W-1:0], got);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [DEB_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [15:0] key_matrix, [47:16] now_ms
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [4:0] key_code, rest zero

  key_scoreboard     sb;
  int                cycle_count = 0;
  int                items_sent  = 0;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                recv_hold   = 0;
  logic [TIME_W-1:0] clock_ms;

  keypad_scan_debounce_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("keypad_scan_debounce_core_tb: done, errors");
      $finish;
    end
  end

  // Handshake monitor: predict on input accept, check on result accept
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_poll(in_tdata[MATRIX_W-1:0], in_tdata[MATRIX_W+TIME_W-1:MATRIX_W]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_key(out_tdata);
    end
  end

  // Result side: random backpressure, or a counted hold-off when requested
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_tready <= 1'b0;
      recv_hold--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one poll, with random gaps first; returns at the next falling edge
  task automatic send_poll(logic [MATRIX_W-1:0] keys, logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, keys};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted item has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.expected_keys.size() != 0) @(posedge clk);
  endtask

  task automatic write_debounce(logic [DEB_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    sb.debounce_ms = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random keystrokes with bounces, plus noise polls and time jumps
  task automatic run_keystrokes(int count);
    int                  stop_at;
    int                  pick;
    int                  step_max;
    int                  hold_len;
    logic [MATRIX_W-1:0] keys;
    logic [MATRIX_W-1:0] after;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick     = $urandom_range(0, 99);
      step_max = int'(sb.debounce_ms) / 2 + 2;
      if (pick < 70) begin
        // one keypress, single key mostly, sometimes several at once
        if ($urandom_range(0, 3) == 0) begin
          keys = MATRIX_W'($urandom());
          if (keys == '0) keys = MATRIX_W'(1);
        end else begin
          keys = MATRIX_W'(1) << $urandom_range(0, MATRIX_W - 1);
        end
        hold_len = $urandom_range(2, 8);
        repeat (hold_len) begin
          clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max));
          if ($urandom_range(0, 19) == 0) begin
            send_poll(MATRIX_W'($urandom()), clock_ms);  // contact bounce
          end else begin
            send_poll(keys, clock_ms);
          end
        end
        // release, or roll over to another key
        after = '0;
        if ($urandom_range(0, 3) == 0) begin
          after = MATRIX_W'(1) << $urandom_range(0, MATRIX_W - 1);
        end
        clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max));
        send_poll(after, clock_ms);
      end else if (pick < 88) begin
        clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max));
        send_poll(MATRIX_W'($urandom()), clock_ms);
      end else begin
        // arbitrary timestamp: wraps and backward steps
        clock_ms = $urandom();
        send_poll(MATRIX_W'($urandom()), clock_ms);
      end
    end
  endtask

  initial begin
    logic [DEB_W-1:0] setting;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 64;
    clock_ms      = '0;
    sb            = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset threshold of 10 ms
    send_poll(16'h0000, 32'h0000_0000);
    send_poll(16'hFFFF, 32'hFFFF_FFFF);      // all keys, max time
    // key 16 held: threshold reached at 10 ms, exceeded at 11 ms
    send_poll(16'h8000, 32'd90);
    send_poll(16'h8000, 32'd100);
    send_poll(16'h8000, 32'd105);
    send_poll(16'h8000, 32'd110);
    send_poll(16'h8000, 32'd111);
    send_poll(16'h8000, 32'd112);
    // several keys: lowest cell wins, change reports key 16
    send_poll(16'h8001, 32'd113);
    send_poll(16'h0011, 32'd114);
    // timestamp steps back: huge elapsed time latches at once
    send_poll(16'h0001, 32'd50);
    send_poll(16'h0000, 32'd200);
    // change during debounce returns to idle
    send_poll(16'h0020, 32'd300);
    send_poll(16'h0020, 32'd301);
    send_poll(16'h0040, 32'd302);
    send_poll(16'h0040, 32'd320);
    send_poll(16'h0000, 32'd400);
    // timer wraps forward past 2^32, then roll over to another key
    send_poll(16'h0100, 32'hFFFF_FFF0);
    send_poll(16'h0100, 32'hFFFF_FFF8);
    send_poll(16'h0100, 32'h0000_0003);
    send_poll(16'h0200, 32'h0000_0004);
    send_poll(16'h0000, 32'h0000_0005);

    // Random phases over several thresholds
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: setting = 16'd0;
        1: setting = 16'hFFFF;
        2: setting = DEB_W'($urandom_range(2, 60));
        default: setting = 16'd1;
      endcase
      write_debounce(setting);
      if (ph == 0) begin
        send_idle_pct = 16;
        recv_idle_pct = 64;
      end else if (ph == 1) begin
        send_idle_pct = 64;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long result stall while polls keep coming, so the input backs up
      if (ph == 2) recv_hold = 300;
      run_keystrokes(ITEMS_PER_SETTING);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("keypad_scan_debounce_core_tb: done, clean");
    end else begin
      $display("keypad_scan_debounce_core_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
